/* hw/rtl/gfc_pkg.sv */
// Package for the gauge float converter: field widths, constants, payload types.
// No dependencies.
package gfc_pkg;
   localparam logic [31:0] ZeroCodeReset = 32'h7027C5AC;
   localparam logic [31:0] GaugeMaxMag   = 32'hFF7FFFFF;
   localparam logic OpDecode = 1'b0;
   localparam logic OpEncode = 1'b1;

   typedef struct packed {
      logic        op;
      logic [31:0] operand_bits;
   } req_type;

   typedef struct packed {
      logic [31:0] result_bits;
      logic        out_of_range;
   } rsp_type;
endpackage

/* hw/rtl/gfc_if.sv */
// Valid/ready channel interface carrying one payload item.
// Depends on gfc_pkg for the payload types.
interface gfc_req_if;
   import gfc_pkg::*;
   logic    valid;
   logic    ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface gfc_rsp_if;
   import gfc_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface gfc_csr_if;
   logic        valid;
   logic        ready;
   logic [31:0] data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

/* hw/rtl/gauge_float_converter.sv */
// Gauge float converter top level: three-stage conversion pipeline.
// Depends on gfc_pkg and the channel interfaces in gfc_if.sv.
//
// Usage:
//  req: one item per handshake, op (0 decode gauge->IEEE, 1 encode IEEE->gauge)
//       and operand_bits. rsp: result_bits and out_of_range for each item.
//  csr: write of zero_code, taken at any time, meant only while idle.
//  Each item passes through the stage 1, 2 and 3 registers before rsp.valid rises.
//  Throughput: one item per cycle while rsp does not stall; stages are split at
//  the priority encode (stage 1), the normalising shift and rounding (stage 2),
//  and the final packing into the output register (stage 3).
//  Reset clears all stage valid bits and loads zero_code with its reset value.
//  When rsp stalls the whole pipeline holds; req.ready drops only when the
//  output register is full and not being taken, so no item is lost or repeated.
module gauge_float_converter (
   input logic    clock,
   input logic    reset,
   gfc_req_if.sink   req,
   gfc_rsp_if.source rsp,
   gfc_csr_if.sink   csr
);
   import gfc_pkg::*;

   logic [31:0] zero_code_ff;
   logic        adv;

   // stage 1
   logic        v1_ff;
   logic        op1_ff;
   logic [31:0] w1_ff;
   logic [4:0]  p1_ff;
   logic [4:0]  p_in;
   // stage 2
   logic        v2_ff;
   logic [31:0] r2_ff;
   logic        f2_ff;
   logic        z2_ff;
   logic [31:0] r_in;
   logic        f_in, z_in;
   // stage 3
   logic        v3_ff;
   rsp_type     o3_ff;

   assign adv       = !v3_ff || rsp.ready;
   assign req.ready = adv;
   assign csr.ready = 1'b1;
   assign rsp.valid = v3_ff;
   assign rsp.data  = o3_ff;

   always_comb begin
      p_in = 5'd0;
      for (int i = 0; i < 23; i++) begin
         if (req.data.operand_bits[i]) p_in = 5'(i);
      end
   end

   always_comb begin
      logic        s;
      logic [7:0]  e;
      logic [22:0] fr;
      logic [23:0] mant, kept;
      logic [1:0]  sh;
      logic [2:0]  rem, half;
      s  = w1_ff[31];
      e  = w1_ff[30:23];
      fr = w1_ff[22:0];
      r_in = '0; f_in = 1'b0; z_in = 1'b0;
      mant = {1'b1, w1_ff[22:0]};
      kept = '0; sh = '0; rem = '0; half = '0;
      if (op1_ff == OpDecode) begin
         e  = w1_ff[31:24];
         s  = w1_ff[23];
         if (e >= 8'd3) begin
            r_in = {s, 8'(e - 8'd2), fr};
         end else begin
            sh   = 2'(2'd3 - e[1:0]);
            kept = mant >> sh;
            rem  = 3'(mant & ((24'd1 << sh) - 24'd1));
            half = 3'(3'd1 << (sh - 2'd1));
            if (rem > half || (rem == half && kept[0])) kept = kept + 24'd1;
            r_in = {s, 7'd0, kept};
         end
      end else if (e == 8'd0) begin
         z_in = 1'b1;
         f_in = (fr != 23'd0) && (p1_ff < 5'd20);
         if (fr != 23'd0 && p1_ff >= 5'd20) begin
            z_in = 1'b0;
            r_in = {8'(p1_ff - 5'd20), s, 23'(fr << (5'd23 - p1_ff))};
         end
      end else if (e >= 8'd254) begin
         f_in = 1'b1;
         r_in = GaugeMaxMag | {8'd0, s, 23'd0};
      end else begin
         r_in = {8'(e + 8'd2), s, fr};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0; v2_ff <= 1'b0; v3_ff <= 1'b0;
         zero_code_ff <= ZeroCodeReset;
      end else begin
         if (csr.valid) zero_code_ff <= csr.data;
         if (adv) begin
            v1_ff <= req.valid;
            v2_ff <= v1_ff;
            v3_ff <= v2_ff;
         end
      end
      if (adv) begin
         op1_ff <= req.data.op;
         w1_ff  <= req.data.operand_bits;
         p1_ff  <= p_in;
         r2_ff  <= r_in;
         f2_ff  <= f_in;
         z2_ff  <= z_in;
         // zero code is applied late; the user must change it only while idle, the block does not enforce this
         o3_ff.result_bits  <= z2_ff ? zero_code_ff : r2_ff;
         o3_ff.out_of_range <= f2_ff;
      end
   end
endmodule

/* test/gfc_checker.sv */
// Checker for the gauge float converter: watches req, rsp and csr channels,
// predicts each result and compares it. Depends on gfc_pkg and gfc_if.sv.
module gfc_checker (
   input  logic        clock,
   input  logic        reset,
   gfc_req_if.sink     req,
   gfc_rsp_if.sink     rsp,
   gfc_csr_if.sink     csr,
   output int unsigned errors,
   output int unsigned pending,
   output int unsigned checked
);
   import gfc_pkg::*;

   logic [31:0] zero_code_q;
   rsp_type     conv_expected[$];

   function automatic rsp_type convert_word(logic op, logic [31:0] w, logic [31:0] zc);
      rsp_type     r;
      logic [7:0]  ex;
      logic        sg;
      logic [22:0] fr;
      logic [23:0] mant;
      logic [23:0] kept;
      logic [23:0] rem;
      logic [23:0] half;
      int          sh;
      int          p;
      r.out_of_range = 1'b0;
      if (op == OpDecode) begin
         ex = w[31:24];
         sg = w[23];
         fr = w[22:0];
         if (ex >= 8'd3) begin
            r.result_bits = {sg, ex - 8'd2, fr};
         end else begin
            mant = {1'b1, fr};
            sh   = 3 - ex;
            kept = mant >> sh;
            rem  = mant & ((24'd1 << sh) - 24'd1);
            half = 24'd1 << (sh - 1);
            if (rem > half || (rem == half && kept[0]))
               kept = kept + 24'd1;
            r.result_bits = {sg, 7'd0, kept};
         end
      end else begin
         sg = w[31];
         ex = w[30:23];
         fr = w[22:0];
         if (ex == 8'd0) begin
            if (fr == 23'd0) begin
               r.result_bits = zc;
            end else begin
               p = 0;
               for (int i = 0; i < 23; i++)
                  if (fr[i])
                     p = i;
               if (p < 20) begin
                  r.result_bits  = zc;
                  r.out_of_range = 1'b1;
               end else begin
                  r.result_bits = {8'(p - 20), sg, 23'(fr << (23 - p))};
               end
            end
         end else if (ex >= 8'd254) begin
            r.result_bits  = GaugeMaxMag | {8'd0, sg, 23'd0};
            r.out_of_range = 1'b1;
         end else begin
            r.result_bits = {ex + 8'd2, sg, fr};
         end
      end
      return r;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         zero_code_q <= ZeroCodeReset;
         conv_expected.delete();
         errors  <= 0;
         checked <= 0;
         pending <= 0;
      end else begin
         if (csr.valid && csr.ready)
            zero_code_q <= csr.data;
         if (rsp.valid && rsp.ready) begin
            checked <= checked + 1;
            if (conv_expected.size() == 0) begin
               $display("%0t: unexpected item result=%h flag=%b", $time,
                        rsp.data.result_bits, rsp.data.out_of_range);
               errors <= errors + 1;
            end else begin
               want = conv_expected.pop_front();
               if (want.result_bits !== rsp.data.result_bits ||
                   want.out_of_range !== rsp.data.out_of_range) begin
                  $display("%0t: mismatch expected %h/%b actual %h/%b", $time,
                           want.result_bits, want.out_of_range,
                           rsp.data.result_bits, rsp.data.out_of_range);
                  errors <= errors + 1;
               end
            end
         end
         // csr writes only happen while idle, so the old value applies here
         if (req.valid && req.ready)
            conv_expected.push_back(convert_word(req.data.op, req.data.operand_bits,
                                                 zero_code_q));
         pending <= conv_expected.size();
      end
   end
endmodule

/* test/tb.sv */
// Testbench top for the gauge float converter: clock, reset, stimulus and verdict.
// Depends on gfc_pkg, gfc_if.sv, the block and gfc_checker.
module tb;
   import gfc_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   int unsigned errors, pending, checked;
   int unsigned gap_left = 0;
   int unsigned stall_phase = 0;

   gfc_req_if req ();
   gfc_rsp_if rsp ();
   gfc_csr_if csr ();

   gauge_float_converter dut (.clock(clock), .reset(reset), .req(req), .rsp(rsp), .csr(csr));
   gfc_checker chk (.clock(clock), .reset(reset), .req(req), .rsp(rsp), .csr(csr),
                    .errors(errors), .pending(pending), .checked(checked));

   always #5 clock = ~clock;

   // receiver stalls in an irregular pattern, with calm stretches
   always @(posedge clock) begin
      stall_phase <= stall_phase + 1;
      if ((stall_phase / 200) % 3 == 0)
         rsp.ready <= 1'b1;
      else
         rsp.ready <= ($urandom_range(0, 99) < 65);
   end

   task automatic send(logic op, logic [31:0] w);
      req.valid     <= 1'b1;
      req.data.op   <= op;
      req.data.operand_bits <= w;
      @(posedge clock);
      while (!req.ready)
         @(posedge clock);
      if (gap_left == 0) begin
         gap_left = $urandom_range(1, 20);
         if ($urandom_range(0, 2) == 0) begin
            req.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
      end
      gap_left--;
   endtask

   task automatic drain();
      req.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0)
         @(posedge clock);
      repeat (5) @(posedge clock);
   endtask

   task automatic write_zero_code(logic [31:0] v);
      csr.valid <= 1'b1;
      csr.data  <= v;
      @(posedge clock);
      while (!csr.ready)
         @(posedge clock);
      csr.valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [31:0] pick_word(logic op);
      logic [31:0] w;
      w = $urandom;
      case ($urandom_range(0, 7))
         0: w[31:24] = 8'($urandom_range(0, 3));
         1: w[31:24] = 8'($urandom_range(252, 255));
         2: if (op == OpEncode) w[30:23] = 8'd0;
         3: if (op == OpEncode) w[30:0] = 31'($urandom_range(0, 32'h7FFFFF));
         default: ;
      endcase
      return w;
   endfunction

   initial begin
      logic [31:0] codes[4];
      req.valid = 1'b0;
      req.data  = '0;
      csr.valid = 1'b0;
      csr.data  = '0;
      codes = '{32'h0000_0000, 32'hFFFF_FFFF, 32'hA5A5_5A5A, ZeroCodeReset};
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // directed: extremes, subnormal rounding, zero, tiny, saturation
      send(OpDecode, 32'h0000_0000);
      send(OpDecode, 32'hFFFF_FFFF);
      send(OpDecode, 32'h0000_0001);
      send(OpDecode, 32'h0000_0004);
      send(OpDecode, 32'h0100_0002);
      send(OpDecode, 32'h027F_FFFF);
      send(OpDecode, 32'h0380_0000);
      send(OpDecode, 32'h8100_0000);
      send(OpEncode, 32'h0000_0000);
      send(OpEncode, 32'h8000_0000);
      send(OpEncode, 32'h0000_0001);
      send(OpEncode, 32'h800F_FFFF);
      send(OpEncode, 32'h0010_0000);
      send(OpEncode, 32'h807F_FFFF);
      send(OpEncode, 32'h7F80_0000);
      send(OpEncode, 32'hFF80_0000);
      send(OpEncode, 32'h7FC0_0001);
      send(OpEncode, 32'h7F00_0000);
      send(OpEncode, 32'h0080_0000);
      send(OpEncode, 32'h7EFF_FFFF);
      send(OpEncode, 32'h3F80_0000);
      drain();
      for (int ph = 0; ph < 4; ph++) begin
         write_zero_code(codes[ph]);
         send(OpEncode, 32'h0000_0000);
         send(OpEncode, 32'h8000_0100);
         for (int i = 0; i < 470; i++) begin
            logic op;
            op = 1'($urandom_range(0, 1));
            send(op, pick_word(op));
         end
         drain();
      end
      $display("Converted %0d items in both directions over 4 zero_code settings.", checked);
      if (errors == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

   initial begin
      #2000000;
      $display("Test completed with failures");
      $finish;
   end
endmodule

/* filelist.f */
hw/rtl/gfc_pkg.sv
hw/rtl/gfc_if.sv
hw/rtl/gauge_float_converter.sv
test/gfc_checker.sv
test/tb.sv
